// ----- hdl/trcd_pkg.sv -----
// Shared types and constants for the text row change drawer.
// No dependencies; imported by trcd_text_ram and text_row_change_drawer.
package trcd_pkg;

   localparam int CODE_W = 8;   // character code width
   localparam int X_W    = 10;  // pixel x width
   localparam int Y_W    = 7;   // pixel y width
   localparam int GW_W   = 4;   // glyph_width register width
   localparam int RH_W   = 5;   // row_height register width
   localparam int ROWF_W = 2;   // width of the row field on the request side

   localparam logic [CODE_W-1:0] SPACE_CODE = 8'h20;

   // CSR register indexes
   localparam logic CSR_GLYPH_WIDTH = 1'b0;
   localparam logic CSR_ROW_HEIGHT  = 1'b1;

   // Sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHAR   = 5'b00010,
      ST_CLR_RD = 5'b00100,
      ST_CLR_CK = 5'b01000,
      ST_FIN    = 5'b10000
   } state_type;

endpackage

// ----- hdl/trcd_text_ram.sv -----
// Text cache RAM: one write port, one read port, registered read data.
// Depends on trcd_pkg for the character code width.
module trcd_text_ram
   import trcd_pkg::*;
#(
   parameter int DEPTH = 160,
   parameter int AW    = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [CODE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [CODE_W-1:0] rd_data
);

   logic [CODE_W-1:0] mem [DEPTH];
   logic [CODE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/text_row_change_drawer.sv -----
// Text row change drawer, top level. Uses trcd_pkg and trcd_text_ram.
// A changed character passes ST_CHAR and the output register to rsp, or waits for the clear pass
// when it ends a row.
// Each character item takes a RAM read, then a compare/write; a draw may stall on rsp_tready.
// A row-end item adds a clear pass (a RAM read, then a check, per old column past the new length)
// and a final draw step; no new request is taken until the item is done.
// Reset (synchronous, active high): lengths, column and control cleared,
// registers back to glyph_width 7 / row_height 12; the text RAM is not cleared.
module text_row_change_drawer
   import trcd_pkg::*;
#(
   parameter int ROWS = 4,
   parameter int COLS = 40
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [1:0] row, [9:2] char_code, rest zero
   input  logic        req_tuser,   // [0] char_present
   input  logic        req_tlast,   // row_end
   // draw stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [9:0] x_pixel, [16:10] y_pixel, [24:17] glyph_code
   output logic        rsp_tlast,   // run_last
   // configuration
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [4:0]  csr_wdata
);

   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;  // row index
   localparam int CW    = $clog2(COLS + 1);               // column, holds COLS
   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int XP_W  = CW + GW_W;                      // x product
   localparam int YP_W  = RW + RH_W;                      // y product

   // RAM address of (row, column)
   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                input logic [CW-1:0] c);
      return AW'(r) * AW'(COLS) + AW'(c);
   endfunction

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [GW_W-1:0] glyph_width_ff;
   logic [RH_W-1:0] row_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_width_ff <= GW_W'(7);
         row_height_ff  <= RH_W'(12);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_GLYPH_WIDTH: glyph_width_ff <= csr_wdata[GW_W-1:0];
            CSR_ROW_HEIGHT:  row_height_ff  <= csr_wdata[RH_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // State
   // ---------------------------------------------------------------
   state_type         state_ff, state_in;
   logic [RW-1:0]     row_ff, row_in;          // saturated row of current item
   logic [CODE_W-1:0] code_ff, code_in;        // character of current item
   logic              end_ff, end_in;          // row_end of current item
   logic [CW-1:0]     next_col_ff, next_col_in;
   logic [CW-1:0]     i_ff, i_in;              // clear-scan column
   logic [CW-1:0]     len_ff [ROWS];           // shown length per row
   logic              len_we;

   // one held draw, so the last draw of an item can be flagged
   logic              pend_valid_ff, pend_valid_in;
   logic [CW-1:0]     pend_col_ff, pend_col_in;
   logic [CODE_W-1:0] pend_code_ff, pend_code_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [X_W-1:0]    rsp_x_ff, rsp_x_in;
   logic [Y_W-1:0]    rsp_y_ff, rsp_y_in;
   logic [CODE_W-1:0] rsp_code_ff, rsp_code_in;
   logic              rsp_last_ff, rsp_last_in;

   // RAM ports
   logic              ram_wr_en, ram_rd_en;
   logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
   logic [CODE_W-1:0] ram_rd_data;

   trcd_text_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (code_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------
   // Request decode
   // ---------------------------------------------------------------
   logic [RW-1:0]     req_row_sat;
   logic              req_xfer;
   logic [CW-1:0]     old_len;
   logic [CODE_W-1:0] old_code;
   logic              slot_free;

   // rows beyond the cache fold onto the last row
   assign req_row_sat = (int'(req_tdata[ROWF_W-1:0]) >= ROWS) ?
                        RW'(ROWS - 1) : RW'(req_tdata[ROWF_W-1:0]);
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_xfer    = req_tvalid && req_tready;

   assign old_len   = len_ff[row_ff];
   // cached cell past the old length reads as a space
   assign old_code  = (next_col_ff < old_len) ? ram_rd_data : SPACE_CODE;
   // output register can take a draw this cycle
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   logic              push;
   logic [CW-1:0]     push_col;
   logic [CODE_W-1:0] push_code;
   logic              push_last;
   logic [XP_W-1:0]   x_prod;
   logic [YP_W-1:0]   y_prod;

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      code_in       = code_ff;
      end_in        = end_ff;
      next_col_in   = next_col_ff;
      i_in          = i_ff;
      pend_valid_in = pend_valid_ff;
      pend_col_in   = pend_col_ff;
      pend_code_in  = pend_code_ff;
      len_we        = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cell_addr(row_ff, next_col_ff);
      ram_rd_en     = 1'b0;
      ram_rd_addr   = cell_addr(row_ff, i_ff);
      push          = 1'b0;
      push_col      = pend_col_ff;
      push_code     = pend_code_ff;
      push_last     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            ram_rd_addr = cell_addr(req_row_sat, next_col_ff);
            if (req_xfer) begin
               row_in  = req_row_sat;
               code_in = req_tdata[ROWF_W +: CODE_W];
               end_in  = req_tlast;
               if (req_tuser && (next_col_ff < CW'(COLS))) begin
                  // fetch the cached cell for this column
                  ram_rd_en = 1'b1;
                  state_in  = ST_CHAR;
               end else if (req_tlast) begin
                  // no character stored: clear from the current column
                  i_in     = next_col_ff;
                  state_in = ST_CLR_RD;
               end
            end
         end

         ST_CHAR: begin
            if (end_ff) begin
               // hold the draw; clears may follow it
               if (code_ff != old_code) begin
                  pend_valid_in = 1'b1;
                  pend_col_in   = next_col_ff;
                  pend_code_in  = code_ff;
               end
               ram_wr_en   = 1'b1;
               next_col_in = next_col_ff + CW'(1);
               i_in        = next_col_ff + CW'(1);
               state_in    = ST_CLR_RD;
            end else if (code_ff == old_code) begin
               ram_wr_en   = 1'b1;
               next_col_in = next_col_ff + CW'(1);
               state_in    = ST_IDLE;
            end else if (slot_free) begin
               // only draw of this item goes straight out
               push        = 1'b1;
               push_col    = next_col_ff;
               push_code   = code_ff;
               push_last   = 1'b1;
               ram_wr_en   = 1'b1;
               next_col_in = next_col_ff + CW'(1);
               state_in    = ST_IDLE;
            end
         end

         ST_CLR_RD: begin
            if (i_ff < old_len) begin
               ram_rd_en = 1'b1;
               state_in  = ST_CLR_CK;
            end else begin
               state_in  = ST_FIN;
            end
         end

         ST_CLR_CK: begin
            if (ram_rd_data != SPACE_CODE) begin
               // stall only if an older draw must leave first
               if (!pend_valid_ff || slot_free) begin
                  push          = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_col_in   = i_ff;
                  pend_code_in  = SPACE_CODE;
                  i_in          = i_ff + CW'(1);
                  state_in      = ST_CLR_RD;
               end
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = ST_CLR_RD;
            end
         end

         ST_FIN: begin
            if (!pend_valid_ff || slot_free) begin
               push          = pend_valid_ff;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
               len_we        = 1'b1;
               next_col_in   = '0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // pixel coordinates of the draw being loaded
   assign x_prod = XP_W'(push_col) * XP_W'(glyph_width_ff);
   assign y_prod = YP_W'(row_ff) * YP_W'(row_height_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = X_W'(x_prod);
         rsp_y_in     = Y_W'(y_prod);
         rsp_code_in  = push_code;
         rsp_last_in  = push_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         next_col_ff   <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int r = 0; r < ROWS; r++) begin
            len_ff[r] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         next_col_ff   <= next_col_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (len_we) begin
            len_ff[row_ff] <= next_col_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      code_ff      <= code_in;
      end_ff       <= end_in;
      i_ff         <= i_in;
      pend_col_ff  <= pend_col_in;
      pend_code_ff <= pend_code_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_code_ff, rsp_y_ff, rsp_x_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- bench/trcd_tb_pkg.sv -----
`timescale 1ns / 1ps
// Bench types and the draw scoreboard for the text row change drawer.
// Depends on trcd_pkg for field widths, SPACE_CODE and the CSR indexes.
package trcd_tb_pkg;
   import trcd_pkg::*;

   localparam int ROWS = 4;
   localparam int COLS = 40;

   typedef struct packed {
      logic [ROWF_W-1:0] row;
      logic [CODE_W-1:0] char_code;
      logic              char_present;
      logic              row_end;
   } text_item_type;

   typedef struct packed {
      logic [X_W-1:0]    x_pixel;
      logic [Y_W-1:0]    y_pixel;
      logic [CODE_W-1:0] glyph_code;
      logic              run_last;
   } draw_type;

   class draw_scoreboard_type;
      logic [GW_W-1:0]   glyph_width;
      logic [RH_W-1:0]   row_height;
      logic [CODE_W-1:0] shown_text [ROWS][COLS];
      bit                text_valid [ROWS][COLS];
      int unsigned       shown_len [ROWS];
      int unsigned       column;
      draw_type          expected_draws [$];
      int unsigned       items_noted;
      int unsigned       draws_seen;
      int unsigned       errors;

      function new();
         glyph_width = 4'd7;
         row_height  = 5'd12;
         column      = 0;
         items_noted = 0;
         draws_seen  = 0;
         errors      = 0;
         foreach (shown_len[r]) shown_len[r] = 0;
         foreach (text_valid[r, c]) begin
            text_valid[r][c] = 1'b0;
            shown_text[r][c] = '0;
         end
      endfunction

      function void write_reg(logic idx, logic [4:0] value);
         if (idx == CSR_GLYPH_WIDTH) begin
            glyph_width = value[GW_W-1:0];
         end else begin
            row_height = value[RH_W-1:0];
         end
      endfunction

      function int unsigned clamp_row(logic [ROWF_W-1:0] row);
         return (row >= ROWS) ? ROWS - 1 : row;
      endfunction

      function int unsigned pending();
         return expected_draws.size();
      endfunction

      // Character the row shows at a column; past its length it shows a space.
      function logic [CODE_W-1:0] shown_at(logic [ROWF_W-1:0] row, int unsigned col);
         int unsigned r;
         r = clamp_row(row);
         if (col >= COLS || col >= shown_len[r]) return SPACE_CODE;
         return shown_text[r][col];
      endfunction

      // A row may close at the current column only if every cell below it was written.
      function bit may_end_on(logic [ROWF_W-1:0] row);
         int unsigned r;
         r = clamp_row(row);
         for (int unsigned i = 0; i < column; i++) begin
            if (!text_valid[r][i]) return 1'b0;
         end
         return 1'b1;
      endfunction

      // A character may go to another row only where the main row is already written.
      function bit may_switch(logic [ROWF_W-1:0] main_row);
         return column >= COLS || text_valid[clamp_row(main_row)][column];
      endfunction

      function void push_draw(int unsigned col, int unsigned r, logic [CODE_W-1:0] code);
         draw_type d;
         d.x_pixel    = X_W'(col * glyph_width);
         d.y_pixel    = Y_W'(r * row_height);
         d.glyph_code = code;
         d.run_last   = 1'b0;
         expected_draws.push_back(d);
      endfunction

      function void note_input(text_item_type it);
         int unsigned r, old_len, col, before_cnt;
         draw_type d;
         r       = clamp_row(it.row);
         old_len = (shown_len[r] > COLS) ? COLS : shown_len[r];
         before_cnt = expected_draws.size();
         items_noted++;
         if (it.char_present && column < COLS) begin
            col = column;
            if (it.char_code != ((col < old_len) ? shown_text[r][col] : SPACE_CODE))
               push_draw(col, r, it.char_code);
            shown_text[r][col] = it.char_code;
            text_valid[r][col] = 1'b1;
            column = col + 1;
         end
         if (it.row_end) begin
            for (int unsigned i = column; i < old_len; i++) begin
               if (shown_text[r][i] != SPACE_CODE) push_draw(i, r, SPACE_CODE);
            end
            shown_len[r] = column;
            column = 0;
         end
         if (expected_draws.size() > before_cnt) begin
            d = expected_draws.pop_back();
            d.run_last = 1'b1;
            expected_draws.push_back(d);
         end
      endfunction

      function void check_draw(logic [31:0] tdata, logic tlast);
         draw_type got, want;
         got.x_pixel    = tdata[X_W-1:0];
         got.y_pixel    = tdata[X_W +: Y_W];
         got.glyph_code = tdata[X_W+Y_W +: CODE_W];
         got.run_last   = tlast;
         draws_seen++;
         if (expected_draws.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: draw with none expected: x=%0d y=%0d code=%02h last=%0b",
                        $realtime, got.x_pixel, got.y_pixel, got.glyph_code, got.run_last);
            return;
         end
         want = expected_draws.pop_front();
         if (got.x_pixel !== want.x_pixel || got.y_pixel !== want.y_pixel ||
             got.glyph_code !== want.glyph_code || got.run_last !== want.run_last) begin
            errors++;
            if (errors <= 10)
               $display("%0t: draw mismatch: exp x=%0d y=%0d code=%02h last=%0b,",
                        $realtime, want.x_pixel, want.y_pixel, want.glyph_code,
                        want.run_last,
                        " got x=%0d y=%0d code=%02h last=%0b",
                        got.x_pixel, got.y_pixel, got.glyph_code, got.run_last);
         end
      endfunction

      function void finish_check();
         if (expected_draws.size() != 0) begin
            $display("%0d expected draws never arrived", expected_draws.size());
            errors += expected_draws.size();
         end
      endfunction
   endclass

endpackage

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Top-level bench for text_row_change_drawer: directed rows, then random row streams.
// Depends on trcd_pkg, trcd_tb_pkg (draw scoreboard) and the drawer RTL.
module tb_top;
   import trcd_pkg::*;
   import trcd_tb_pkg::*;

   localparam int PHASES    = 6;
   localparam int PER_PHASE = 59;   // random row items per phase
   localparam int SETTLE    = 2 * COLS + 8;   // longest row-end clearing pass, plus margin

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // [1:0] row, [9:2] char_code, rest zero
   logic        req_tuser;    // [0] char_present
   logic        req_tlast;    // row_end
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [9:0] x_pixel, [16:10] y_pixel, [24:17] glyph_code
   logic        rsp_tlast;    // run_last
   logic        csr_we;
   logic        csr_addr;
   logic [4:0]  csr_wdata;

   draw_scoreboard_type sb;
   int gap_pct;     // chance in 100 that the sender idles a cycle
   int stall_pct;   // chance in 100 that the receiver holds tready low
   int settings_used;

   // Register settings per phase; glyph width values above 15 check that bit 4 is dropped.
   int gw_set    [PHASES] = '{15, 1, 19, 0, 31, 9};
   int rh_set    [PHASES] = '{31, 1, 5, 0, 16, 12};
   int gap_set   [PHASES] = '{0, 68, 0, 32, 68, 0};
   int stall_set [PHASES] = '{0, 0, 68, 32, 0, 68};

   text_row_change_drawer #(.ROWS(ROWS), .COLS(COLS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Draw receiver. Values read right after the edge are the ones the DUT saw
   // at that edge, so a transfer is exactly tvalid && tready here.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_draw(rsp_tdata, rsp_tlast);
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // One request transfer. tvalid is left high afterwards so back-to-back
   // items never drop and raise it in the same step.
   task automatic send_item(logic [1:0] row, logic [7:0] code, logic present, logic row_end);
      text_item_type it;
      it.row          = row;
      it.char_code    = code;
      it.char_present = present;
      it.row_end      = row_end;
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, code, row};
      req_tuser  <= present;
      req_tlast  <= row_end;
      do @(posedge clock); while (!req_tready);
      sb.note_input(it);
   endtask

   // Idle point: no request pending, all draws in, and time for a row end
   // that draws nothing to finish its clearing pass.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [4:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   // Character content: random bytes, an echo of what the row shows now
   // (mostly no draws), or mostly spaces.
   function automatic logic [7:0] next_code(logic [1:0] main_row, int style);
      case (style)
         0: return 8'($urandom);
         1: begin
            if ($urandom_range(3) == 0) return 8'($urandom);
            return sb.shown_at(main_row, sb.column);
         end
         default: begin
            if ($urandom_range(9) < 7) return SPACE_CODE;
            return 8'($urandom_range(8'h21, 8'h7E));
         end
      endcase
   endfunction

   // One row of text. Mostly on its main row; now and then a character or
   // the row end lands on another row, and ignored items are mixed in. Row
   // switches are held back where they would leave unwritten cells inside a
   // stored length.
   task automatic send_row(logic [1:0] main_row, int len, int style);
      logic [1:0] row;
      bit         end_in_char;
      end_in_char = (len > 0) && $urandom_range(1);
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(19) == 0)
            send_item(2'($urandom), 8'($urandom), 1'b0, 1'b0);
         row = main_row;
         if ($urandom_range(9) == 0 && sb.may_switch(main_row)) row = 2'($urandom);
         if (end_in_char && k == len - 1 && !sb.may_end_on(row)) row = main_row;
         send_item(row, next_code(main_row, style), 1'b1, end_in_char && k == len - 1);
      end
      if (!end_in_char) begin
         row = ($urandom_range(6) == 0) ? 2'($urandom) : main_row;
         if (!sb.may_end_on(row)) row = main_row;
         send_item(row, 8'($urandom), 1'b0, 1'b1);
      end
   endtask

   initial begin
      int len;
      sb = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = 1'b0;
      csr_wdata  = '0;
      gap_pct    = 0;
      stall_pct  = 0;
      settings_used = 1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows at the reset steps (7 x 12).
      send_item(2'd0, "H", 1'b1, 1'b0);          // fresh row: both drawn
      send_item(2'd0, "i", 1'b1, 1'b1);
      send_item(2'd0, "H", 1'b1, 1'b0);          // same text again: no draws
      send_item(2'd0, "i", 1'b1, 1'b1);
      send_item(2'd0, "H", 1'b1, 1'b0);          // shorter row ended by an item without a char
      send_item(2'd0, 8'hFF, 1'b0, 1'b1);
      send_item(2'd3, 8'hFF, 1'b1, 1'b0);        // code extremes, code zero, a space
      send_item(2'd3, 8'h00, 1'b1, 1'b0);
      send_item(2'd3, SPACE_CODE, 1'b1, 1'b0);
      send_item(2'd3, 8'h80, 1'b1, 1'b1);
      send_item(2'd0, 8'h00, 1'b0, 1'b1);        // empty row clears what is left
      send_item(2'd2, 8'h55, 1'b0, 1'b0);        // ignored item
      send_item(2'd2, 8'hAA, 1'b1, 1'b1);
      send_item(2'd3, 8'h00, 1'b1, 1'b1);        // redraw column 0, clear the non-spaces
      send_item(2'd3, "a", 1'b1, 1'b0);          // row switch mid-row, back for the end
      send_item(2'd1, "b", 1'b1, 1'b0);
      send_item(2'd3, "c", 1'b1, 1'b1);
      drain();

      // Random rows, one register setting and idling mix per phase. Long
      // rows run past the column limit.
      for (int p = 0; p < PHASES; p++) begin
         write_csr(CSR_GLYPH_WIDTH, 5'(gw_set[p]));
         write_csr(CSR_ROW_HEIGHT, 5'(rh_set[p]));
         settings_used++;
         gap_pct   = gap_set[p];
         stall_pct = stall_set[p];
         while (sb.items_noted < 17 + (p + 1) * PER_PHASE) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(30, 44) : $urandom_range(0, 12);
            send_row(2'($urandom), len, $urandom_range(2));
         end
         drain();
      end

      sb.finish_check();
      $display("Ran %0d row items through %0d register settings; %0d draws checked.",
               sb.items_noted, settings_used, sb.draws_seen);
      $display("Mismatches: %0d", sb.errors);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("Run timed out");
      $display("Simulation FAILED");
      $finish;
   end

endmodule
